/* sv/sbcpu_pkg.sv */
// Shared constants, types and helper functions for the sixteen-bit CPU core.
// Holds item codes, instruction opcodes, the sequencer state type and memory index math.
// Depends on nothing; the top-level core and the testbench import it.
`default_nettype none

package sbcpu_pkg;

    // Byte memory geometry.
    localparam int RAM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(RAM_DEPTH);

    // Reset values of the configuration registers.
    localparam logic [15:0] STACK_TOP_RESET   = 16'hFFFE;
    localparam logic [15:0] STACK_FLOOR_RESET = 16'h1000;

    // Configuration register indexes.
    localparam logic CFG_STACK_FLOOR = 1'b1;

    // Item operation codes.
    localparam logic [1:0] OP_WR   = 2'd0;
    localparam logic [1:0] OP_RD   = 2'd1;
    localparam logic [1:0] OP_EXEC = 2'd2;
    localparam logic [1:0] OP_REG  = 2'd3;

    // Instruction opcodes.
    localparam logic [4:0] OPC_NOP  = 5'h00;
    localparam logic [4:0] OPC_HALT = 5'h01;
    localparam logic [4:0] OPC_LDL  = 5'h02;
    localparam logic [4:0] OPC_LDH  = 5'h03;
    localparam logic [4:0] OPC_LDI  = 5'h04;
    localparam logic [4:0] OPC_STA  = 5'h05;
    localparam logic [4:0] OPC_ST   = 5'h06;
    localparam logic [4:0] OPC_LD   = 5'h07;
    localparam logic [4:0] OPC_MOV  = 5'h08;
    localparam logic [4:0] OPC_ADD  = 5'h09;
    localparam logic [4:0] OPC_SUB  = 5'h0A;
    localparam logic [4:0] OPC_AND  = 5'h0B;
    localparam logic [4:0] OPC_OR   = 5'h0C;
    localparam logic [4:0] OPC_XOR  = 5'h0D;
    localparam logic [4:0] OPC_SHL  = 5'h0E;
    localparam logic [4:0] OPC_SHR  = 5'h0F;
    localparam logic [4:0] OPC_CMP  = 5'h10;
    localparam logic [4:0] OPC_JZ   = 5'h11;
    localparam logic [4:0] OPC_JNZ  = 5'h12;
    localparam logic [4:0] OPC_JS   = 5'h13;
    localparam logic [4:0] OPC_JNS  = 5'h14;
    localparam logic [4:0] OPC_JC   = 5'h15;
    localparam logic [4:0] OPC_JNC  = 5'h16;
    localparam logic [4:0] OPC_JMP  = 5'h17;
    localparam logic [4:0] OPC_PUSH = 5'h18;
    localparam logic [4:0] OPC_POP  = 5'h19;
    localparam logic [4:0] OPC_CALL = 5'h1A;
    localparam logic [4:0] OPC_RET  = 5'h1B;
    localparam logic [4:0] OPC_LDX  = 5'h1C;
    localparam logic [4:0] OPC_STX  = 5'h1D;
    localparam logic [4:0] OPC_MUL  = 5'h1E;
    localparam logic [4:0] OPC_DIV  = 5'h1F;

    // Flag bit positions.
    localparam int FLAG_Z = 0;
    localparam int FLAG_S = 1;
    localparam int FLAG_C = 2;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_MEMRD, ST_RES,
        ST_RW0, ST_RW1, ST_RW2, ST_WW0, ST_WW1, ST_WB,
        ST_INS, ST_RA, ST_RB, ST_RS, ST_EXEC,
        ST_SETB, ST_IDX, ST_ALU, ST_DIV, ST_AWB,
        ST_LDI, ST_STAA, ST_BR, ST_CALLA, ST_RETA, ST_POPA, ST_POPB,
        ST_L0, ST_L1, ST_L2, ST_L3, ST_FIN
    } state_t;

    // Reduces a 16-bit address modulo RAM_DEPTH. The quotient is below 16,
    // so four conditional subtracts of scaled depths are enough.
    function automatic logic [MEM_AW-1:0] mem_index(input logic [15:0] a);
        logic [19:0] v;
        logic [19:0] dep;
        v   = {4'b0000, a};
        dep = 20'(RAM_DEPTH);
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (dep << k))
            begin
                v = v - (dep << k);
            end
        end
        return v[MEM_AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/sbcpu_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Used for the byte memory of the CPU core; depends on nothing.
`default_nettype none

module sbcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* sv/sixteen_bit_cpu_core.sv */
// Top level of the sixteen-bit CPU core: sequencer, register file, ALU and divider.
// Depends on sbcpu_pkg and on sbcpu_ram for the byte memory.
//
// The item channel (item_valid / item_stall) carries one operation: write a memory
// byte, read a memory byte, read a register, or execute the instruction at pc.
// Every item gives exactly one result on the result channel (result_valid /
// result_stall) with the read value, the pc, the flags and the run state.
// Items are handled one at a time by a sequencer around one byte-wide memory
// port, so the cost is set by memory accesses: an instruction is a fetch,
// operand reads and up to six byte accesses, and a divide also runs the
// bit-serial divider.
// After reset the core sweeps the memory to zero, one byte a cycle, over every
// address; item_stall stays high through the sweep. Registers reset to zero,
// register seven to the stack top, pc and flags to zero, run state to one.
// A finished result sits in the output register; the next item is accepted while
// it waits, and a stalled result holds until taken. Configuration writes are
// taken at any time and only the stack floor is kept: the stack top is a reset
// value, so a write to it has no lasting effect.
`default_nettype none

module sixteen_bit_cpu_core
    import sbcpu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    // item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [2:0]  reg_index,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      read_data,
    output logic [15:0]      pc_now,
    output logic [2:0]       flag_bits,
    output logic             is_running
);

    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(RAM_DEPTH - 1);

    // Sequencer state.
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;

    // Architectural state outside the memory.
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  flags_reg, flags_next;
    logic        run_reg, run_next;
    logic [15:0] floor_reg;

    // Working registers of one instruction.
    logic [15:0] ins_reg, ins_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [15:0] s_reg, s_next;
    logic [15:0] ma_reg, ma_next;
    logic [15:0] wd_reg, wd_next;
    logic [15:0] mw_reg, mw_next;
    logic [15:0] npc_reg, npc_next;
    logic [15:0] rd_reg, rd_next;
    logic [15:0] res_reg, res_next;
    logic        cy_reg, cy_next;

    // Divider.
    logic [15:0] dq_reg, dq_next;
    logic [15:0] drem_reg, drem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [3:0]  cnt_reg, cnt_next;

    // Result register.
    logic        result_valid_reg, result_valid_next;
    logic [15:0] read_data_reg, read_data_next;
    logic [15:0] pc_now_reg, pc_now_next;
    logic [2:0]  flag_bits_reg, flag_bits_next;
    logic        is_running_reg, is_running_next;

    // Register file ports.
    logic [2:0]  rf_ridx;
    logic [15:0] rf_rdata;
    logic [2:0]  rf_widx;
    logic        rf_we_lo;
    logic        rf_we_hi;
    logic [15:0] rf_wdata;

    // Memory port.
    logic              mem_we;
    logic              mem_inc;
    logic [15:0]       mem_a16;
    logic [7:0]        mem_wd;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_rdata;

    // Instruction fields.
    logic [4:0] opc;
    logic [2:0] r1;
    logic [2:0] r2;
    logic       szb;
    logic       lob;
    logic       mfb;
    logic [7:0] imm8;
    logic [15:0] pc_p2;
    logic [15:0] pc_p4;
    logic        cond;
    logic        item_take;

    // ALU.
    logic [15:0] opa;
    logic [15:0] opb;
    logic [3:0]  shamt;
    logic [16:0] sum17;
    logic [16:0] dif17;
    logic [30:0] shl_w;
    logic [31:0] prod;
    logic [15:0] alu_r;
    logic        alu_c;

    // Divider step.
    logic [16:0] rem_sh;
    logic [16:0] rem_dif;
    logic        q_bit;

    logic [15:0] sp_m2;
    logic [15:0] pop_sp;

    assign opc  = ins_reg[15:11];
    assign r1   = ins_reg[10:8];
    assign r2   = ins_reg[7:5];
    assign szb  = ins_reg[4];
    assign lob  = ins_reg[3];
    assign mfb  = ins_reg[2];
    assign imm8 = ins_reg[7:0];

    assign pc_p2  = pc_reg + 16'd2;
    assign pc_p4  = pc_reg + 16'd4;
    assign sp_m2  = s_reg - 16'd2;
    assign pop_sp = ((r1 == 3'd7) ? mw_reg : s_reg) + 16'd2;

    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && (state_reg == ST_IDLE);

    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign pc_now       = pc_now_reg;
    assign flag_bits    = flag_bits_reg;
    assign is_running   = is_running_reg;

    // Branch condition from the current flags.
    always_comb
    begin
        case (opc)
            OPC_JZ:  cond = flags_reg[FLAG_Z];
            OPC_JNZ: cond = !flags_reg[FLAG_Z];
            OPC_JS:  cond = flags_reg[FLAG_S];
            OPC_JNS: cond = !flags_reg[FLAG_S];
            OPC_JC:  cond = flags_reg[FLAG_C];
            OPC_JNC: cond = !flags_reg[FLAG_C];
            default: cond = 1'b1;
        endcase
    end

    // Operand selection: byte forms work on one half, zero extended, and judge
    // flags on the unclipped result just like the word forms.
    always_comb
    begin
        if (szb)
        begin
            opa = lob ? {8'h00, a_reg[7:0]} : {8'h00, a_reg[15:8]};
            opb = lob ? {8'h00, b_reg[7:0]} : {8'h00, b_reg[15:8]};
        end
        else
        begin
            opa = a_reg;
            opb = b_reg;
        end
        shamt = szb ? {1'b0, opb[2:0]} : opb[3:0];
    end

    assign sum17 = {1'b0, opa} + {1'b0, opb};
    assign dif17 = {1'b0, opa} - {1'b0, opb};
    assign shl_w = {15'd0, opa} << shamt;
    assign prod  = opa * opb;

    always_comb
    begin
        alu_r = 16'h0000;
        alu_c = 1'b0;
        case (opc)
            OPC_ADD:
            begin
                alu_r = sum17[15:0];
                alu_c = sum17[16];
            end
            OPC_SUB, OPC_CMP:
            begin
                // A borrow leaves the unclipped difference above 16 bits.
                alu_r = dif17[15:0];
                alu_c = dif17[16];
            end
            OPC_AND: alu_r = opa & opb;
            OPC_OR:  alu_r = opa | opb;
            OPC_XOR: alu_r = opa ^ opb;
            OPC_SHL:
            begin
                alu_r = shl_w[15:0];
                alu_c = |shl_w[30:16];
            end
            OPC_SHR: alu_r = opa >> shamt;
            OPC_MUL:
            begin
                alu_r = prod[15:0];
                alu_c = |prod[31:16];
            end
            OPC_DIV: alu_r = szb ? 16'h00FF : 16'hFFFF;
            default:
            begin
                alu_r = 16'h0000;
                alu_c = 1'b0;
            end
        endcase
    end

    // One restoring divide step per cycle.
    assign rem_sh  = {drem_reg, dq_reg[15]};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};
    assign q_bit   = !rem_dif[16];

    // Register file read port.
    always_comb
    begin
        case (state_reg)
            ST_IDLE: rf_ridx = reg_index;
            ST_RA:   rf_ridx = r1;
            ST_RB:   rf_ridx = r2;
            default: rf_ridx = 3'd7;
        endcase
    end
    assign rf_rdata = rf_reg[rf_ridx];

    // Memory address: the item address while idle, else the working address
    // plus one for the second byte of a word.
    assign mem_a16  = ((state_reg == ST_IDLE) ? address : ma_reg) + {15'd0, mem_inc};
    assign mem_addr = (state_reg == ST_CLEAR) ? clr_reg : mem_index(mem_a16);

    sbcpu_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wd),
        .rdata (mem_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (op)
                        OP_WR:   state_next = ST_RES;
                        OP_RD:   state_next = ST_MEMRD;
                        OP_REG:  state_next = ST_RES;
                        OP_EXEC: state_next = run_reg ? ST_RW0 : ST_RES;
                        default: state_next = ST_RES;
                    endcase
                end
            end
            ST_MEMRD: state_next = ST_RES;
            ST_RES:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RW0: state_next = ST_RW1;
            ST_RW1: state_next = ST_RW2;
            ST_RW2: state_next = ret_reg;
            ST_WW0: state_next = ST_WW1;
            ST_WW1: state_next = ret_reg;
            ST_WB:  state_next = ST_FIN;
            ST_INS: state_next = ST_RA;
            ST_RA:  state_next = ST_RB;
            ST_RB:  state_next = ST_RS;
            ST_RS:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (opc) inside
                    OPC_NOP, OPC_HALT, OPC_LDL, OPC_LDH, OPC_MOV:
                        state_next = ST_FIN;
                    OPC_LDI, OPC_STA, OPC_CALL, OPC_POP, OPC_RET, OPC_LDX, OPC_STX:
                        state_next = ST_RW0;
                    OPC_ST:
                        state_next = szb ? ST_WB : ST_WW0;
                    OPC_LD:
                        state_next = ST_L0;
                    OPC_PUSH:
                        state_next = ST_WW0;
                    OPC_JZ, OPC_JNZ, OPC_JS, OPC_JNS, OPC_JC, OPC_JNC, OPC_JMP:
                        state_next = cond ? ST_RW0 : ST_FIN;
                    default:
                    begin
                        if (szb || (lob && !mfb))
                        begin
                            state_next = ST_ALU;
                        end
                        else
                        begin
                            state_next = ST_RW0;
                        end
                    end
                endcase
            end
            ST_SETB: state_next = ST_ALU;
            ST_IDX:  state_next = (opc == OPC_STX) ? ST_WW0 : ST_RW0;
            ST_ALU:  state_next = ((opc == OPC_DIV) && (opb != 16'h0000)) ? ST_DIV : ST_AWB;
            ST_DIV:  state_next = (cnt_reg == 4'd0) ? ST_AWB : ST_DIV;
            ST_AWB:  state_next = ST_FIN;
            ST_LDI:  state_next = ST_FIN;
            ST_STAA: state_next = ST_WW0;
            ST_BR:   state_next = ST_FIN;
            ST_CALLA: state_next = ST_WW0;
            ST_RETA: state_next = ST_FIN;
            ST_POPA: state_next = ST_POPB;
            ST_POPB: state_next = ST_FIN;
            ST_L0:   state_next = ST_L1;
            ST_L1:   state_next = szb ? ST_FIN : ST_L2;
            ST_L2:   state_next = ST_L3;
            ST_L3:   state_next = ST_FIN;
            ST_FIN:  state_next = ST_RES;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs of each state.
    always_comb
    begin
        ret_next   = ret_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        flags_next = flags_reg;
        run_next   = run_reg;
        ins_next   = ins_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        s_next     = s_reg;
        ma_next    = ma_reg;
        wd_next    = wd_reg;
        mw_next    = mw_reg;
        npc_next   = npc_reg;
        rd_next    = rd_reg;
        res_next   = res_reg;
        cy_next    = cy_reg;
        dq_next    = dq_reg;
        drem_next  = drem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;

        result_valid_next = result_valid_reg && result_stall;
        read_data_next    = read_data_reg;
        pc_now_next       = pc_now_reg;
        flag_bits_next    = flag_bits_reg;
        is_running_next   = is_running_reg;

        rf_widx  = r1;
        rf_we_lo = 1'b0;
        rf_we_hi = 1'b0;
        rf_wdata = 16'h0000;

        mem_we  = 1'b0;
        mem_inc = 1'b0;
        mem_wd  = 8'h00;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (item_take)
                begin
                    rd_next = 16'h0000;
                    unique case (op)
                        OP_WR:
                        begin
                            mem_we = 1'b1;
                            mem_wd = data;
                        end
                        OP_REG:  rd_next = rf_rdata;
                        OP_EXEC:
                        begin
                            ma_next  = pc_reg;
                            ret_next = ST_INS;
                        end
                        default: rd_next = 16'h0000;
                    endcase
                end
            end
            ST_MEMRD: rd_next = {8'h00, mem_rdata};
            ST_RES:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    read_data_next    = rd_reg;
                    pc_now_next       = pc_reg;
                    flag_bits_next    = flags_reg;
                    is_running_next   = run_reg;
                end
            end
            ST_RW0: mem_inc = 1'b0;
            ST_RW1:
            begin
                mem_inc = 1'b1;
                mw_next = {8'h00, mem_rdata};
            end
            ST_RW2: mw_next = {mem_rdata, mw_reg[7:0]};
            ST_WW0:
            begin
                mem_we = 1'b1;
                mem_wd = wd_reg[7:0];
            end
            ST_WW1:
            begin
                mem_we  = 1'b1;
                mem_inc = 1'b1;
                mem_wd  = wd_reg[15:8];
            end
            ST_WB:
            begin
                mem_we = 1'b1;
                mem_wd = wd_reg[7:0];
            end
            ST_INS: ins_next = mw_reg;
            ST_RA:  a_next = rf_rdata;
            ST_RB:  b_next = rf_rdata;
            ST_RS:  s_next = rf_rdata;
            ST_EXEC:
            begin
                npc_next = pc_p2;
                unique case (opc) inside
                    OPC_NOP: npc_next = pc_p2;
                    OPC_HALT: run_next = 1'b0;
                    OPC_LDL:
                    begin
                        rf_we_lo = 1'b1;
                        rf_wdata = {imm8, imm8};
                    end
                    OPC_LDH:
                    begin
                        rf_we_hi = 1'b1;
                        rf_wdata = {imm8, imm8};
                    end
                    OPC_LDI:
                    begin
                        npc_next = pc_p4;
                        ma_next  = pc_p2;
                        ret_next = ST_LDI;
                    end
                    OPC_STA:
                    begin
                        npc_next = pc_p4;
                        ma_next  = pc_p2;
                        ret_next = ST_STAA;
                    end
                    OPC_ST:
                    begin
                        ma_next  = b_reg;
                        ret_next = ST_FIN;
                        if (szb)
                        begin
                            wd_next = lob ? a_reg : {8'h00, a_reg[15:8]};
                        end
                        else
                        begin
                            wd_next = a_reg;
                        end
                    end
                    OPC_LD: ma_next = b_reg;
                    OPC_MOV:
                    begin
                        if (!szb)
                        begin
                            rf_we_lo = 1'b1;
                            rf_we_hi = 1'b1;
                            rf_wdata = b_reg;
                        end
                        else if (!lob)
                        begin
                            rf_we_hi = 1'b1;
                            rf_wdata = b_reg;
                        end
                        else
                        begin
                            rf_we_lo = 1'b1;
                            rf_wdata = b_reg;
                        end
                    end
                    OPC_JZ, OPC_JNZ, OPC_JS, OPC_JNS, OPC_JC, OPC_JNC, OPC_JMP:
                    begin
                        npc_next = pc_p4;
                        ma_next  = pc_p2;
                        ret_next = ST_BR;
                    end
                    OPC_PUSH:
                    begin
                        // The new stack pointer is stored first, so pushing
                        // register seven pushes its decremented value.
                        rf_widx  = 3'd7;
                        rf_we_lo = 1'b1;
                        rf_we_hi = 1'b1;
                        rf_wdata = sp_m2;
                        ma_next  = sp_m2;
                        wd_next  = (r1 == 3'd7) ? sp_m2 : a_reg;
                        ret_next = ST_FIN;
                    end
                    OPC_POP:
                    begin
                        ma_next  = s_reg;
                        ret_next = ST_POPA;
                    end
                    OPC_CALL:
                    begin
                        ma_next  = pc_p2;
                        ret_next = ST_CALLA;
                    end
                    OPC_RET:
                    begin
                        ma_next  = s_reg;
                        ret_next = ST_RETA;
                    end
                    OPC_LDX, OPC_STX:
                    begin
                        npc_next = pc_p4;
                        ma_next  = pc_p2;
                        ret_next = ST_IDX;
                    end
                    default:
                    begin
                        // ALU group: immediate or memory operand forms are four
                        // bytes long.
                        if (!szb && !(lob && !mfb))
                        begin
                            npc_next = pc_p4;
                            ma_next  = pc_p2;
                            ret_next = lob ? ST_IDX : ST_SETB;
                        end
                    end
                endcase
            end
            ST_SETB: b_next = mw_reg;
            ST_IDX:
            begin
                ma_next = b_reg + mw_reg;
                if (opc == OPC_STX)
                begin
                    wd_next  = a_reg;
                    ret_next = ST_FIN;
                end
                else if (opc == OPC_LDX)
                begin
                    ret_next = ST_LDI;
                end
                else
                begin
                    ret_next = ST_SETB;
                end
            end
            ST_ALU:
            begin
                res_next  = alu_r;
                cy_next   = alu_c;
                dq_next   = opa;
                drem_next = 16'h0000;
                dvs_next  = opb;
                cnt_next  = 4'd15;
            end
            ST_DIV:
            begin
                dq_next   = {dq_reg[14:0], q_bit};
                drem_next = q_bit ? rem_dif[15:0] : rem_sh[15:0];
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    res_next = {dq_reg[14:0], q_bit};
                    cy_next  = 1'b0;
                end
            end
            ST_AWB:
            begin
                flags_next[FLAG_Z] = (res_reg == 16'h0000);
                flags_next[FLAG_S] = res_reg[15];
                flags_next[FLAG_C] = cy_reg;
                if (opc != OPC_CMP)
                begin
                    if (szb)
                    begin
                        rf_wdata = {res_reg[7:0], res_reg[7:0]};
                        rf_we_lo = lob;
                        rf_we_hi = !lob;
                    end
                    else
                    begin
                        rf_wdata = res_reg;
                        rf_we_lo = 1'b1;
                        rf_we_hi = 1'b1;
                    end
                end
            end
            ST_LDI:
            begin
                rf_we_lo = 1'b1;
                rf_we_hi = 1'b1;
                rf_wdata = mw_reg;
            end
            ST_STAA:
            begin
                ma_next  = mw_reg;
                wd_next  = a_reg;
                ret_next = ST_FIN;
            end
            ST_BR: npc_next = mw_reg;
            ST_CALLA:
            begin
                npc_next = mw_reg;
                rf_widx  = 3'd7;
                rf_we_lo = 1'b1;
                rf_we_hi = 1'b1;
                rf_wdata = sp_m2;
                ma_next  = sp_m2;
                wd_next  = pc_p4;
                ret_next = ST_FIN;
            end
            ST_RETA:
            begin
                npc_next = mw_reg;
                rf_widx  = 3'd7;
                rf_we_lo = 1'b1;
                rf_we_hi = 1'b1;
                rf_wdata = s_reg + 16'd2;
            end
            ST_POPA:
            begin
                rf_we_lo = 1'b1;
                rf_we_hi = 1'b1;
                rf_wdata = mw_reg;
            end
            ST_POPB:
            begin
                rf_widx  = 3'd7;
                rf_we_lo = 1'b1;
                rf_we_hi = 1'b1;
                rf_wdata = pop_sp;
                if (pop_sp < floor_reg)
                begin
                    // Stack underflow halts with pc left on the pop.
                    run_next = 1'b0;
                    npc_next = pc_reg;
                end
            end
            ST_L0: mem_inc = 1'b0;
            ST_L1:
            begin
                rf_wdata = {mem_rdata, mem_rdata};
                if (szb)
                begin
                    rf_we_lo = lob;
                    rf_we_hi = !lob;
                end
                else
                begin
                    // The second byte address follows the base register as it
                    // now stands, which matters when it is the destination.
                    rf_we_lo = 1'b1;
                    ma_next  = ((r1 == r2) ? {b_reg[15:8], mem_rdata} : b_reg) + 16'd1;
                end
            end
            ST_L2: mem_inc = 1'b0;
            ST_L3:
            begin
                rf_we_hi = 1'b1;
                rf_wdata = {mem_rdata, mem_rdata};
            end
            ST_FIN: pc_next = npc_reg;
            default: mem_inc = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            ret_reg          <= ST_FIN;
            clr_reg          <= '0;
            pc_reg           <= 16'h0000;
            flags_reg        <= 3'b000;
            run_reg          <= 1'b1;
            floor_reg        <= STACK_FLOOR_RESET;
            result_valid_reg <= 1'b0;
            cnt_reg          <= 4'd0;
        end
        else
        begin
            state_reg        <= state_next;
            ret_reg          <= ret_next;
            clr_reg          <= clr_next;
            pc_reg           <= pc_next;
            flags_reg        <= flags_next;
            run_reg          <= run_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
            if (cfg_write && (cfg_index == CFG_STACK_FLOOR))
            begin
                floor_reg <= cfg_data;
            end
        end
    end

    // Register file with byte-lane write enables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= (i == 7) ? STACK_TOP_RESET : 16'h0000;
            end
        end
        else
        begin
            if (rf_we_lo)
            begin
                rf_reg[rf_widx][7:0] <= rf_wdata[7:0];
            end
            if (rf_we_hi)
            begin
                rf_reg[rf_widx][15:8] <= rf_wdata[15:8];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ins_reg        <= ins_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        s_reg          <= s_next;
        ma_reg         <= ma_next;
        wd_reg         <= wd_next;
        mw_reg         <= mw_next;
        npc_reg        <= npc_next;
        rd_reg         <= rd_next;
        res_reg        <= res_next;
        cy_reg         <= cy_next;
        dq_reg         <= dq_next;
        drem_reg       <= drem_next;
        dvs_reg        <= dvs_next;
        read_data_reg  <= read_data_next;
        pc_now_reg     <= pc_now_next;
        flag_bits_reg  <= flag_bits_next;
        is_running_reg <= is_running_next;
    end

`ifndef NO_ASSERTIONS
    // Once halted, only a reset restarts the core.
    a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |=> !run_reg)
        else $error("run state rose without reset");

    // The program counter moves only when an instruction retires.
    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FIN) |=> (pc_reg == $past(pc_reg)))
        else $error("pc changed outside instruction retire");

    // A halted core never fetches or executes.
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> (state_reg == ST_IDLE || state_reg == ST_MEMRD ||
                      state_reg == ST_RES || state_reg == ST_FIN ||
                      state_reg == ST_CLEAR))
        else $error("halted core left the idle states");
`endif

endmodule

`default_nettype wire

/* verif/sixteen_bit_cpu_core_test.sv */
// Self-checking testbench for sixteen_bit_cpu_core: directed table, then random programs.
// Depends on sbcpu_pkg for item codes, opcodes and RAM_DEPTH; needs only the RTL.
// Results are predicted by an in-bench model of the CPU and checked field by field.
`default_nettype none

module sixteen_bit_cpu_core_test;
    import sbcpu_pkg::*;

    // The package names only the stack floor index; the stack top is index zero.
    localparam logic CFG_STACK_TOP = 1'b0;

    // Generous bound: the clearing sweep, about 1700 items, random gaps and
    // stalls on both sides, and one long hold-off.
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLDOFF_LEN = 300;
    localparam int ITEMS_PER_PHASE = 400;

    typedef struct packed {
        logic [15:0] rd;
        logic [15:0] pc;
        logic [2:0]  fl;
        logic        run;
    } result_t;

    // One row of the directed table. For an execute row the loop first places
    // the instruction word and its immediate at the predicted pc.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  dat;
        logic [2:0]  ri;
        logic [15:0] ins;
        logic [15:0] imm;
        logic        typed;
        result_t     exp;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'h0000;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  op = OP_RD;
    logic [15:0] address = 16'h0000;
    logic [7:0]  data = 8'h00;
    logic [2:0]  reg_index = 3'd0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] read_data;
    logic [15:0] pc_now;
    logic [2:0]  flag_bits;
    logic        is_running;

    sixteen_bit_cpu_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .address      (address),
        .data         (data),
        .reg_index    (reg_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_data    (read_data),
        .pc_now       (pc_now),
        .flag_bits    (flag_bits),
        .is_running   (is_running)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predicted machine state, kept in step with every accepted item.
    logic [7:0]  mem_img [0:RAM_DEPTH-1];
    logic [15:0] gpr [0:7];
    logic [15:0] pc_q;
    logic [2:0]  flags_q;
    logic        running_q;
    logic [15:0] floor_q;
    logic [15:0] top_q;

    result_t     result_q [$];
    result_t     seen_exp;
    bit          failed = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    bit          holdoff_done = 1'b0;

    function automatic int unsigned mem_addr(input int unsigned a);
        return (a & 32'hFFFF) % RAM_DEPTH;
    endfunction

    function automatic logic [7:0] rd8(input int unsigned a);
        return mem_img[mem_addr(a)];
    endfunction

    function automatic logic [15:0] rd16(input int unsigned a);
        return {rd8(a + 1), rd8(a)};
    endfunction

    task automatic wr8(input int unsigned a, input logic [7:0] v);
        mem_img[mem_addr(a)] = v;
    endtask

    task automatic wr16(input int unsigned a, input logic [15:0] v);
        wr8(a, v[7:0]);
        wr8(a + 1, v[15:8]);
    endtask

    // Flags judge the unclipped 32-bit result: zero and sign look at the low
    // word, carry at anything beyond it.
    task automatic set_flags(input logic [31:0] res);
        flags_q[FLAG_Z] = (res[15:0] == 16'h0000);
        flags_q[FLAG_S] = res[15];
        flags_q[FLAG_C] = (res > 32'h0000FFFF);
    endtask

    function automatic logic [31:0] alu_calc(input logic [4:0] opc, input logic [31:0] a,
                                             input logic [31:0] b, input bit half);
        case (opc)
            OPC_ADD:          return a + b;
            OPC_SUB, OPC_CMP: return a - b;
            OPC_AND:          return a & b;
            OPC_OR:           return a | b;
            OPC_XOR:          return a ^ b;
            OPC_SHL:          return a << (b & (half ? 32'h7 : 32'hF));
            OPC_SHR:          return a >> (b & (half ? 32'h7 : 32'hF));
            OPC_MUL:          return a * b;
            OPC_DIV:          return (b == 0) ? (half ? 32'hFF : 32'hFFFF) : a / b;
            default:          return 32'h0;
        endcase
    endfunction

    // Arithmetic and logic instructions; a compare keeps only the flags.
    task automatic alu_instr(input logic [4:0] opc, input logic [2:0] r1, input logic [2:0] r2,
                             input logic sz, input logic lo, input logic mf);
        logic [31:0] b;
        logic [31:0] res;
        logic [15:0] step;
        bit          keep;
        keep = (opc != OPC_CMP);
        if (!sz)
        begin
            step = 16'd4;
            if (!lo)
                b = rd16(pc_q + 2);
            else if (!mf)
            begin
                b = gpr[r2];
                step = 16'd2;
            end
            else
                b = rd16(16'(gpr[r2] + rd16(pc_q + 2)));
            res = alu_calc(opc, gpr[r1], b, 1'b0);
            if (keep)
                gpr[r1] = res[15:0];
            set_flags(res);
            pc_q = pc_q + step;
        end
        else
        begin
            if (!lo)
            begin
                res = alu_calc(opc, gpr[r1][15:8], gpr[r2][15:8], 1'b1);
                if (keep)
                    gpr[r1][15:8] = res[7:0];
            end
            else
            begin
                res = alu_calc(opc, gpr[r1][7:0], gpr[r2][7:0], 1'b1);
                if (keep)
                    gpr[r1][7:0] = res[7:0];
            end
            set_flags(res);
            pc_q = pc_q + 16'd2;
        end
    endtask

    // One instruction at pc. Steps run in order, so a register that serves as
    // both base and destination is seen as it stands at each step.
    task automatic cpu_exec();
        logic [15:0] ins;
        logic [4:0]  opc;
        logic [2:0]  r1;
        logic [2:0]  r2;
        logic [15:0] pc2;
        logic [15:0] pc4;
        logic [15:0] tmp;
        bit          cond;
        ins = rd16(pc_q);
        opc = ins[15:11];
        r1  = ins[10:8];
        r2  = ins[7:5];
        pc2 = pc_q + 16'd2;
        pc4 = pc_q + 16'd4;
        case (opc)
            OPC_NOP:  pc_q = pc2;
            OPC_HALT:
            begin
                running_q = 1'b0;
                pc_q = pc2;
            end
            OPC_LDL:
            begin
                gpr[r1][7:0] = ins[7:0];
                pc_q = pc2;
            end
            OPC_LDH:
            begin
                gpr[r1][15:8] = ins[7:0];
                pc_q = pc2;
            end
            OPC_LDI:
            begin
                gpr[r1] = rd16(pc_q + 2);
                pc_q = pc4;
            end
            OPC_STA:
            begin
                tmp = rd16(pc_q + 2);
                wr8(tmp, gpr[r1][7:0]);
                wr8(tmp + 1, gpr[r1][15:8]);
                pc_q = pc4;
            end
            OPC_ST:
            begin
                if (!ins[4])
                begin
                    wr8(gpr[r2], gpr[r1][7:0]);
                    wr8(gpr[r2] + 1, gpr[r1][15:8]);
                end
                else
                    wr8(gpr[r2], ins[3] ? gpr[r1][7:0] : gpr[r1][15:8]);
                pc_q = pc2;
            end
            OPC_LD:
            begin
                if (!ins[4])
                begin
                    gpr[r1][7:0] = rd8(gpr[r2]);
                    gpr[r1][15:8] = rd8(gpr[r2] + 1);
                end
                else if (!ins[3])
                    gpr[r1][15:8] = rd8(gpr[r2]);
                else
                    gpr[r1][7:0] = rd8(gpr[r2]);
                pc_q = pc2;
            end
            OPC_MOV:
            begin
                if (!ins[4])
                    gpr[r1] = gpr[r2];
                else if (!ins[3])
                    gpr[r1][15:8] = gpr[r2][15:8];
                else
                    gpr[r1][7:0] = gpr[r2][7:0];
                pc_q = pc2;
            end
            OPC_JZ, OPC_JNZ, OPC_JS, OPC_JNS, OPC_JC, OPC_JNC, OPC_JMP:
            begin
                case (opc)
                    OPC_JZ:  cond = flags_q[FLAG_Z];
                    OPC_JNZ: cond = !flags_q[FLAG_Z];
                    OPC_JS:  cond = flags_q[FLAG_S];
                    OPC_JNS: cond = !flags_q[FLAG_S];
                    OPC_JC:  cond = flags_q[FLAG_C];
                    OPC_JNC: cond = !flags_q[FLAG_C];
                    default: cond = 1'b1;
                endcase
                pc_q = cond ? rd16(pc_q + 2) : pc4;
            end
            OPC_PUSH:
            begin
                gpr[7] = gpr[7] - 16'd2;
                wr16(gpr[7], gpr[r1]);
                pc_q = pc2;
            end
            OPC_POP:
            begin
                gpr[r1] = rd16(gpr[7]);
                gpr[7] = gpr[7] + 16'd2;
                // Stack underflow stops the machine with pc left on the pop.
                if (gpr[7] < floor_q)
                    running_q = 1'b0;
                else
                    pc_q = pc2;
            end
            OPC_CALL:
            begin
                tmp = rd16(pc_q + 2);
                gpr[7] = gpr[7] - 16'd2;
                wr16(gpr[7], pc4);
                pc_q = tmp;
            end
            OPC_RET:
            begin
                tmp = rd16(gpr[7]);
                gpr[7] = gpr[7] + 16'd2;
                pc_q = tmp;
            end
            OPC_LDX:
            begin
                gpr[r1] = rd16(16'(gpr[r2] + rd16(pc_q + 2)));
                pc_q = pc4;
            end
            OPC_STX:
            begin
                wr16(16'(gpr[r2] + rd16(pc_q + 2)), gpr[r1]);
                pc_q = pc4;
            end
            default: alu_instr(opc, r1, r2, ins[4], ins[3], ins[2]);
        endcase
    endtask

    task automatic cpu_apply(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
                             input logic [2:0] r, output result_t res);
        logic [15:0] rv;
        rv = 16'h0000;
        case (o)
            OP_WR:   wr8(a, d);
            OP_RD:   rv = {8'h00, rd8(a)};
            OP_EXEC:
            begin
                if (running_q)
                    cpu_exec();
            end
            default: rv = gpr[r];
        endcase
        res = '{rd: rv, pc: pc_q, fl: flags_q, run: running_q};
    endtask

    // Offers one item, at a falling edge, in bursts separated by random gaps.
    // Returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
                             input logic [2:0] r, input logic typed, input result_t typed_res);
        result_t res;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        op = o;
        address = a;
        data = d;
        reg_index = r;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        cpu_apply(o, a, d, r, res);
        result_q.push_back(typed ? typed_res : res);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
                              input logic [2:0] r);
        send_item(o, a, d, r, 1'b0, '0);
    endtask

    // Writes an instruction and its immediate at the predicted pc, then executes it.
    task automatic run_instr(input logic [15:0] ins, input logic [15:0] imm);
        logic [15:0] at;
        at = pc_q;
        send_plain(OP_WR, at, ins[7:0], $urandom);
        send_plain(OP_WR, at + 16'd1, ins[15:8], $urandom);
        send_plain(OP_WR, at + 16'd2, imm[7:0], $urandom);
        send_plain(OP_WR, at + 16'd3, imm[15:8], $urandom);
        send_plain(OP_EXEC, $urandom, $urandom, $urandom);
    endtask

    // Waits until every result is back and the core has settled, then writes.
    task automatic write_config(input logic idx, input logic [15:0] v);
        item_valid = 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_STACK_FLOOR)
            floor_q = v;
        else
            top_q = v;   // only read at reset, so it has no effect in this run
    endtask

    function automatic logic [15:0] enc(input logic [4:0] opc, input logic [2:0] r1,
                                        input logic [2:0] r2, input logic sz,
                                        input logic lo, input logic mf);
        return {opc, r1, r2, sz, lo, mf, 2'b00};
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(1 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Random instruction word. Halt is kept for the end of the run, and pops
    // only appear when the floor is zero, so the machine keeps running.
    function automatic logic [15:0] pick_instr();
        logic [4:0] opc;
        opc = $urandom_range(0, 31);
        while (opc == OPC_HALT || (opc == OPC_POP && floor_q != 16'h0000))
            opc = $urandom_range(0, 31);
        return {opc, 11'($urandom)};
    endfunction

    function automatic bit safe_at_pc();
        logic [4:0] opc;
        opc = rd8(pc_q + 1) >> 3;
        return !(opc == OPC_HALT || (opc == OPC_POP && floor_q != 16'h0000));
    endfunction

    // One random step: mostly placed instructions with random content, the rest
    // memory traffic, register reads and execution of whatever sits at pc.
    task automatic random_step();
        int unsigned sel;
        logic [15:0] a;
        sel = $urandom_range(0, 99);
        a = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        if (sel < 70)
            run_instr(pick_instr(), pick_imm());
        else if (sel < 80)
            send_plain(OP_WR, a, $urandom, $urandom);
        else if (sel < 88)
            send_plain(OP_RD, a, $urandom, $urandom);
        else if (sel < 95)
            send_plain(OP_REG, $urandom, $urandom, $urandom);
        else if (safe_at_pc())
            send_plain(OP_EXEC, $urandom, $urandom, $urandom);
        else
            send_plain(OP_REG, $urandom, $urandom, $urandom);
    endtask

    // Result checker: every taken result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result with nothing expected: read_data %h pc_now %h", read_data, pc_now);
                failed = 1'b1;
            end
            else
            begin
                seen_exp = result_q.pop_front();
                if (read_data !== seen_exp.rd)
                begin
                    $error("read_data: expected %h, actual %h", seen_exp.rd, read_data);
                    failed = 1'b1;
                end
                if (pc_now !== seen_exp.pc)
                begin
                    $error("pc_now: expected %h, actual %h", seen_exp.pc, pc_now);
                    failed = 1'b1;
                end
                if (flag_bits !== seen_exp.fl)
                begin
                    $error("flag_bits: expected %b, actual %b", seen_exp.fl, flag_bits);
                    failed = 1'b1;
                end
                if (is_running !== seen_exp.run)
                begin
                    $error("is_running: expected %b, actual %b", seen_exp.run, is_running);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side stalls. It switches among no stalls, random stalls and a rotating
    // mask, and once holds off for a long stretch while items keep coming, so the
    // core fills up and stalls its input.
    initial
    begin : result_side
        int unsigned stall_mode;
        int unsigned mode_left;
        logic [31:0] stall_mask;
        stall_mode = 0;
        mode_left = 0;
        stall_mask = '0;
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && items_sent >= 500)
            begin
                result_stall = 1'b1;
                repeat (HOLDOFF_LEN) @(negedge clk);
                holdoff_done = 1'b1;
                result_stall = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_mask = $urandom;
                    mode_left = 64;
                end
                mode_left--;
                case (stall_mode)
                    0:       result_stall = 1'b0;
                    1:       result_stall = ($urandom_range(0, 2) == 0);
                    default: result_stall = stall_mask[mode_left % 32];
                endcase
            end
        end
    end

    // Stimulus: reset, directed table, random phases under several stack floors,
    // and finally a stop of the machine followed by execute items that must do nothing.
    initial
    begin : stimulus
        row_t        rows [$];
        row_t        row;
        logic [15:0] floors [4];
        int unsigned start;

        for (int k = 0; k < RAM_DEPTH; k++)
            mem_img[k] = 8'h00;
        for (int k = 0; k < 8; k++)
            gpr[k] = 16'h0000;
        top_q = STACK_TOP_RESET;
        floor_q = STACK_FLOOR_RESET;
        gpr[7] = top_q;
        pc_q = 16'h0000;
        flags_q = 3'b000;
        running_q = 1'b1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows. Typed expectations only where the answer is plain:
        // reset values and byte writes and reads at the last memory address and at 00FF.
        rows.push_back('{OP_REG, 16'h0, 8'h0, 3'd7, 16'h0, 16'h0, 1'b1,
                         '{16'hFFFE, 16'h0, 3'b000, 1'b1}});
        rows.push_back('{OP_REG, 16'h0, 8'h0, 3'd0, 16'h0, 16'h0, 1'b1,
                         '{16'h0000, 16'h0, 3'b000, 1'b1}});
        rows.push_back('{OP_RD, 16'hFFFF, 8'h0, 3'd0, 16'h0, 16'h0, 1'b1,
                         '{16'h0000, 16'h0, 3'b000, 1'b1}});
        rows.push_back('{OP_WR, 16'hFFFF, 8'hFF, 3'd0, 16'h0, 16'h0, 1'b1,
                         '{16'h0000, 16'h0, 3'b000, 1'b1}});
        rows.push_back('{OP_RD, 16'hFFFF, 8'h0, 3'd0, 16'h0, 16'h0, 1'b1,
                         '{16'h00FF, 16'h0, 3'b000, 1'b1}});
        rows.push_back('{OP_WR, 16'h00FF, 8'h34, 3'd0, 16'h0, 16'h0, 1'b1,
                         '{16'h0000, 16'h0, 3'b000, 1'b1}});
        // Word divide by zero gives all ones.
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_LDI, 1, 0, 0, 0, 0), 16'hFFFF,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_LDI, 2, 0, 0, 0, 0), 16'h0000,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_DIV, 1, 2, 0, 1, 0), 16'h0,
                         1'b0, '0});
        // Byte add with carry out sets neither zero nor carry; byte borrow sets
        // sign and carry; byte divide by zero gives 0xFF.
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, {OPC_LDL, 3'd3, 8'hFF}, 16'h0,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, {OPC_LDL, 3'd4, 8'h01}, 16'h0,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_ADD, 3, 4, 1, 1, 0), 16'h0,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_SUB, 4, 3, 1, 1, 0), 16'h0,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_DIV, 4, 0, 1, 1, 0), 16'h0,
                         1'b0, '0});
        // Load word into its own base register: the high byte comes through
        // the base as already changed by the low byte.
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_LDI, 5, 0, 0, 0, 0), 16'h00FF,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_LD, 5, 5, 0, 0, 0), 16'h0,
                         1'b0, '0});
        rows.push_back('{OP_REG, 16'h0, 8'h0, 3'd5, 16'h0, 16'h0, 1'b0, '0});
        // Word store at the last address continues at address zero.
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_STA, 1, 0, 0, 0, 0), 16'hFFFF,
                         1'b0, '0});
        rows.push_back('{OP_RD, 16'h0000, 8'h0, 3'd0, 16'h0, 16'h0, 1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_MUL, 1, 0, 0, 0, 0), 16'hFFFF,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_SHL, 1, 4, 1, 0, 0), 16'h0,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_CMP, 1, 2, 0, 1, 1), 16'hFFFF,
                         1'b0, '0});
        rows.push_back('{OP_EXEC, 16'h0, 8'h0, 3'd0, enc(OPC_JNZ, 0, 0, 0, 0, 0), 16'h0200,
                         1'b0, '0});
        rows.push_back('{OP_REG, 16'h0, 8'h0, 3'd1, 16'h0, 16'h0, 1'b0, '0});

        foreach (rows[k])
        begin
            row = rows[k];
            if (row.op == OP_EXEC)
                run_instr(row.ins, row.imm);
            else
                send_item(row.op, row.addr, row.dat, row.ri, row.typed, row.exp);
        end

        // Random phases, each under its own stack floor; both stack top
        // extremes are written too, which must change nothing before a reset.
        floors[0] = 16'h0000;
        floors[1] = 16'hFFFF;
        floors[2] = 16'($urandom);
        floors[3] = 16'h0000;
        for (int p = 0; p < 4; p++)
        begin
            write_config(CFG_STACK_FLOOR, floors[p]);
            if (p == 1)
                write_config(CFG_STACK_TOP, 16'h0000);
            if (p == 2)
                write_config(CFG_STACK_TOP, 16'hFFFF);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE)
                random_step();
        end

        // Stop the machine: a pop under the highest floor, or a halt where
        // that pop would land exactly on the floor.
        write_config(CFG_STACK_FLOOR, 16'hFFFF);
        if ($urandom_range(0, 1) == 0 && 16'(gpr[7] + 16'd2) != 16'hFFFF)
            run_instr(enc(OPC_POP, 0, 0, 0, 0, 0), 16'h0);
        else
            run_instr(enc(OPC_HALT, 0, 0, 0, 0, 0), 16'h0);
        repeat (3)
            send_plain(OP_EXEC, $urandom, $urandom, $urandom);
        send_plain(OP_REG, $urandom, $urandom, $urandom);
        send_plain(OP_RD, pc_q, $urandom, $urandom);

        item_valid = 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/sbcpu_pkg.sv
sv/sbcpu_ram.sv
sv/sixteen_bit_cpu_core.sv
verif/sixteen_bit_cpu_core_test.sv
